@@ sv/mtg_pkg.sv @@
package mtg_pkg;

  localparam int STATE_WORDS = 624;
  localparam int TAP_OFFSET  = 397;
  localparam int LOWER_BITS  = 31;
  localparam int PTR_W       = $clog2(STATE_WORDS);

  localparam logic [31:0] INIT_MULT  = 32'd1812433253;
  localparam logic [31:0] TWIST_XOR  = 32'h9908_B0DF;
  localparam logic [31:0] TEMPER_B   = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C   = 32'hEFC6_0000;
  localparam logic [31:0] TWIST_LO_MASK = (32'h1 << LOWER_BITS) - 32'h1;

  typedef enum logic {
    ACT_DRAW   = 1'b0,
    ACT_RESEED = 1'b1
  } action_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] seed;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SEED,
    BK_EXEC
  } back_state_t;

  function automatic logic [31:0] twist(input logic [31:0] cur, input logic [31:0] nxt,
                                        input logic [31:0] tap);
    logic [31:0] x;
    x = (cur & ~TWIST_LO_MASK) | (nxt & TWIST_LO_MASK);
    return tap ^ (x >> 1) ^ (x[0] ? TWIST_XOR : 32'h0);
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] v);
    logic [31:0] y;
    y = v ^ (v >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    return y ^ (y >> 18);
  endfunction

endpackage

@@ sv/mtg_front.sv @@
module mtg_front #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_action,
  input  logic [31:0]         in_seed,
  output logic                busy,
  input  logic                pop,
  output mtg_pkg::queue_t     q
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  mtg_pkg::item_t slots_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           push;
  logic           do_pop;

  assign busy   = (count_r == CW'(DEPTH));
  assign push   = start && !busy;
  assign do_pop = pop && (count_r != '0);

  assign q.valid = (count_r != '0);
  assign q.item  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= '{action: mtg_pkg::action_t'(in_action), seed: in_seed};
    end
  end

endmodule

@@ sv/mtg_back.sv @@
module mtg_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mtg_pkg::queue_t     q,
  output logic                pop,
  output logic                out_strobe,
  output logic [31:0]         out_word
);

  localparam int PW = mtg_pkg::PTR_W;

  logic [31:0] words [mtg_pkg::STATE_WORDS];

  mtg_pkg::back_state_t state_r, state_nxt;
  logic [PW-1:0] ptr_r, idx_r;
  logic [31:0]   cur_r, prev_r;
  logic [31:0]   rd_nxt_r, rd_tap_r;
  logic          strobe_r;
  logic [31:0]   word_r;

  logic          we;
  logic [PW-1:0] waddr;
  logic [31:0]   wdata;
  logic          rd_en;
  logic [PW-1:0] nxt_ptr, tap_ptr;
  logic [PW:0]   tap_sum;
  logic [31:0]   mixed, seed_word, twisted;
  logic          start_seed;

  assign nxt_ptr = (ptr_r == PW'(mtg_pkg::STATE_WORDS - 1)) ? '0 : ptr_r + 1'b1;
  assign tap_sum = {1'b0, ptr_r} + (PW + 1)'(mtg_pkg::TAP_OFFSET);
  always_comb begin
    if (tap_sum >= (PW + 1)'(mtg_pkg::STATE_WORDS)) begin
      tap_ptr = PW'(tap_sum - (PW + 1)'(mtg_pkg::STATE_WORDS));
    end else begin
      tap_ptr = tap_sum[PW-1:0];
    end
  end

  // init recurrence, one word per cycle
  assign mixed     = prev_r ^ (prev_r >> 30);
  assign seed_word = mixed * mtg_pkg::INIT_MULT + {{(32 - PW){1'b0}}, idx_r};
  // cur_r holds the word at the pointer, so only next and tap come from memory
  assign twisted   = mtg_pkg::twist(cur_r, rd_nxt_r, rd_tap_r);

  assign start_seed = (state_r == mtg_pkg::BK_IDLE) && q.valid &&
                      (q.item.action == mtg_pkg::ACT_RESEED);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mtg_pkg::BK_IDLE: begin
        if (q.valid) begin
          state_nxt = (q.item.action == mtg_pkg::ACT_RESEED) ? mtg_pkg::BK_SEED
                                                             : mtg_pkg::BK_EXEC;
        end
      end
      mtg_pkg::BK_SEED: begin
        if (idx_r == PW'(mtg_pkg::STATE_WORDS - 1)) begin
          state_nxt = mtg_pkg::BK_IDLE;
        end
      end
      mtg_pkg::BK_EXEC: state_nxt = mtg_pkg::BK_IDLE;
      default:          state_nxt = mtg_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop   = 1'b0;
    we    = 1'b0;
    waddr = ptr_r;
    wdata = twisted;
    rd_en = 1'b0;
    case (state_r)
      mtg_pkg::BK_IDLE: begin
        pop   = q.valid;
        rd_en = q.valid;
        if (start_seed) begin
          we    = 1'b1;
          waddr = '0;
          wdata = q.item.seed;
        end
      end
      mtg_pkg::BK_SEED: begin
        we    = 1'b1;
        waddr = idx_r;
        wdata = seed_word;
      end
      mtg_pkg::BK_EXEC: begin
        we    = 1'b1;
        waddr = ptr_r;
        wdata = twisted;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      words[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_nxt_r <= words[nxt_ptr];
      rd_tap_r <= words[tap_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mtg_pkg::BK_IDLE;
      ptr_r    <= '0;
      idx_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= (state_r == mtg_pkg::BK_EXEC);
      if (start_seed) begin
        ptr_r <= '0;
        idx_r <= PW'(1);
      end else if (state_r == mtg_pkg::BK_SEED) begin
        idx_r <= idx_r + 1'b1;
      end else if (state_r == mtg_pkg::BK_EXEC) begin
        ptr_r <= nxt_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_seed) begin
      prev_r <= q.item.seed;
      cur_r  <= q.item.seed;
    end else if (state_r == mtg_pkg::BK_SEED) begin
      prev_r <= seed_word;
    end else if (state_r == mtg_pkg::BK_EXEC) begin
      cur_r  <= rd_nxt_r;
      word_r <= mtg_pkg::temper(twisted);
    end
  end

  assign out_strobe = strobe_r;
  assign out_word   = word_r;

endmodule

@@ sv/mersenne_twister_generator.sv @@
// channel   ports                              handshake
// input     in_action, in_seed                 beat taken when start && !busy
// result    out_word                           one-cycle beat on out_strobe
//
// a draw in the back end: the idle state pops it and reads the next and tap words
// from the two read ports of the state memory, then the exec state twists, writes back
// and registers the tempered word; out_strobe is registered alongside that word.
// a reseed writes the seed as word 0, then the other 623 words, one multiply per word of the init recurrence.
// busy rises only when the input queue is full; results cannot be stalled.
// reset clears the pointer and control state; the state memory is not cleared.
module mersenne_twister_generator #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [31:0] in_seed,
  output logic        out_strobe,
  output logic [31:0] out_word
);

  mtg_pkg::queue_t q;
  logic            pop;

  mtg_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .in_seed   (in_seed),
    .busy      (busy),
    .pop       (pop),
    .q         (q)
  );

  mtg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q          (q),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

`ifndef SYNTHESIS
  // a popped draw beat yields its word once the exec state has registered it
  a_draw_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && q.valid && q.item.action == mtg_pkg::ACT_DRAW) |-> ##2 out_strobe)
    else $error("draw did not produce a word on time");

  // the back end only pops when the queue has a beat
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q.valid)
    else $error("pop from empty queue");

  // the back end returns to idle after each exec, so strobes never come back to back
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("back-to-back result strobes");

  // a reseed beat gives no result
  a_reseed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && q.valid && q.item.action == mtg_pkg::ACT_RESEED) |-> ##2 !out_strobe)
    else $error("reseed produced a result");
`endif

endmodule

@@ sim/mtg_checker.sv @@
module mtg_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_action,
  input  logic [31:0] in_seed,
  input  logic        out_strobe,
  input  logic [31:0] out_word,
  output int          fail_count,
  output int          words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW = mtg_pkg::PTR_W;

  logic [31:0]   pool [mtg_pkg::STATE_WORDS];
  logic [PW-1:0] draw_ptr;
  logic [31:0]   due_words [$];

  function automatic logic [31:0] temper_word(input logic [31:0] raw);
    logic [31:0] t;
    t = raw;
    t = t ^ {11'b0, t[31:11]};
    t = t ^ ({t[24:0], 7'b0} & mtg_pkg::TEMPER_B);
    t = t ^ ({t[16:0], 15'b0} & mtg_pkg::TEMPER_C);
    t = t ^ {18'b0, t[31:18]};
    return t;
  endfunction

  task automatic reseed_pool(input logic [31:0] s);
    logic [31:0] prev;
    pool[0] = s;
    for (int k = 1; k < mtg_pkg::STATE_WORDS; k++) begin
      prev = pool[k-1];
      pool[k] = mtg_pkg::INIT_MULT * (prev ^ {30'b0, prev[31:30]}) + 32'(k);
    end
    draw_ptr = '0;
  endtask

  // one word of the twist, in pointer order
  task automatic draw_pool(output logic [31:0] w);
    int          here;
    int          after;
    int          tap;
    logic [31:0] mixed;
    here  = int'(draw_ptr);
    after = (here + 1) % mtg_pkg::STATE_WORDS;
    tap   = (here + mtg_pkg::TAP_OFFSET) % mtg_pkg::STATE_WORDS;
    mixed = (pool[here] & ~mtg_pkg::TWIST_LO_MASK) | (pool[after] & mtg_pkg::TWIST_LO_MASK);
    pool[here] = pool[tap] ^ {1'b0, mixed[31:1]} ^ (mixed[0] ? mtg_pkg::TWIST_XOR : 32'h0);
    draw_ptr = PW'(after);
    w = temper_word(pool[here]);
  endtask

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst_n) begin
      draw_ptr = '0;
      due_words.delete();
      fail_count    <= 0;
      words_pending <= 0;
    end else begin
      if (out_strobe) begin
        if (due_words.size() == 0) begin
          $display("%0t: out_word expected none, actual %h", $time, out_word);
          fail_count <= fail_count + 1;
        end else begin
          want = due_words.pop_front();
          if (want !== out_word) begin
            $display("%0t: out_word expected %h, actual %h", $time, want, out_word);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        if (mtg_pkg::action_t'(in_action) == mtg_pkg::ACT_RESEED) begin
          reseed_pool(in_seed);
        end else begin
          draw_pool(want);
          due_words.push_back(want);
        end
      end
      words_pending <= due_words.size();
    end
  end

endmodule

@@ sim/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 6000;
  localparam int TAIL_CYCLES = 640;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_action;
  logic [31:0] in_seed;
  logic        out_strobe;
  logic [31:0] out_word;
  int          fail_count;
  int          words_pending;
  int          idle_pct;
  int          quiet_cycles;

  mersenne_twister_generator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_action  (in_action),
    .in_seed    (in_seed),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

  mtg_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_action     (in_action),
    .in_seed       (in_seed),
    .out_strobe    (out_strobe),
    .out_word      (out_word),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // start stays high across back-to-back beats
  task automatic send_item(input mtg_pkg::action_t act, input logic [31:0] s);
    logic took;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    in_action <= act;
    in_seed   <= s;
    do begin
      @(negedge clk);
      took = !busy;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic send_random(input int count, input int reseed_one_in);
    for (int n = 0; n < count; n++) begin
      if (reseed_one_in > 0 && $urandom_range(1, reseed_one_in) == 1) begin
        send_item(mtg_pkg::ACT_RESEED, $urandom());
      end else begin
        send_item(mtg_pkg::ACT_DRAW, $urandom());
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_action    = mtg_pkg::ACT_DRAW;
    in_seed      = '0;
    idle_pct     = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: seed extremes, ignored seed on draws, back-to-back reseeds
    send_item(mtg_pkg::ACT_RESEED, 32'd5489);
    send_item(mtg_pkg::ACT_DRAW, 32'h0000_0000);
    send_item(mtg_pkg::ACT_DRAW, 32'hFFFF_FFFF);
    send_item(mtg_pkg::ACT_DRAW, $urandom());
    send_item(mtg_pkg::ACT_RESEED, 32'h0000_0000);
    send_item(mtg_pkg::ACT_DRAW, 32'hFFFF_FFFF);
    send_item(mtg_pkg::ACT_DRAW, 32'h0000_0000);
    send_item(mtg_pkg::ACT_RESEED, 32'hFFFF_FFFF);
    send_item(mtg_pkg::ACT_DRAW, 32'h5555_AAAA);
    send_item(mtg_pkg::ACT_RESEED, 32'h8000_0000);
    send_item(mtg_pkg::ACT_RESEED, 32'h0000_0001);
    send_item(mtg_pkg::ACT_DRAW, 32'hAAAA_5555);
    send_item(mtg_pkg::ACT_DRAW, $urandom());
    send_item(mtg_pkg::ACT_RESEED, 32'hAAAA_5555);
    send_item(mtg_pkg::ACT_DRAW, $urandom());
    send_item(mtg_pkg::ACT_DRAW, $urandom());
    send_item(mtg_pkg::ACT_DRAW, $urandom());

    idle_pct = 31;
    send_random(120, 20);
    idle_pct = 62;
    send_random(120, 20);
    // long unbroken run walks the pointer and the tap index past the wrap
    idle_pct = 0;
    send_item(mtg_pkg::ACT_RESEED, $urandom());
    send_random(690, 0);
    start <= 1'b0;

    while (words_pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
